FILE: hdl/pixel_median_engine_core_macros.svh
// Assertion macros shared by the median engine RTL.
`ifndef PIXEL_MEDIAN_ENGINE_CORE_MACROS_SVH
`define PIXEL_MEDIAN_ENGINE_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define PME_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
`define PME_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define PME_ASSERT_SAME(lbl, ante, cons)
`define PME_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: hdl/pme_pkg.sv
// Types and constants of the pixel median engine.
package pme_pkg;

  localparam int PIX_W    = 8;
  localparam int NUM_BINS = 256;
  localparam int BIN_W    = 8;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_SCAN,
    ST_FINISH
  } pme_state_t;

  typedef struct packed {
    logic             count_en;
    logic             shift;
    logic [PIX_W-1:0] pixel;
  } pme_cell_ctrl_t;

  typedef struct packed {
    logic             clear;
    logic             step;
    logic [BIN_W-1:0] bin;
  } pme_eval_ctrl_t;

endpackage

FILE: hdl/pme_hist_cell.sv
// One histogram bin cell: counts matching pixels, shifts its count to its neighbor on scan.
module pme_hist_cell
  import pme_pkg::*;
#(
  parameter int CNT_W = 13,
  parameter int BIN   = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pme_cell_ctrl_t       ctrl,
  input  logic [CNT_W-1:0]     count_in,
  output logic [CNT_W-1:0]     count_out
);

  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.shift) begin
      count <= count_in;
    end else if (ctrl.count_en && (ctrl.pixel == PIX_W'(BIN))) begin
      count <= count + CNT_W'(1);
    end
  end

  assign count_out = count;

endmodule

FILE: hdl/pme_rank_eval.sv
// Rank evaluator at the chain end: accumulates bin counts and picks the middle values.
module pme_rank_eval
  import pme_pkg::*;
#(
  parameter int CNT_W = 13
) (
  input  logic               clk,
  input  logic               rst,
  input  pme_eval_ctrl_t     ctrl,
  input  logic [CNT_W-1:0]   total,
  input  logic [CNT_W-1:0]   count_in,
  output logic [PIX_W-1:0]   median
);

  logic [CNT_W-1:0] seen;
  logic [CNT_W-1:0] seen_next;
  logic [CNT_W-1:0] hi_rank;
  logic [CNT_W-1:0] lo_rank;
  logic             lo_found;
  logic             hi_found;
  logic [BIN_W-1:0] lo_val;
  logic [BIN_W-1:0] hi_val;
  logic [BIN_W:0]   mid_sum;

  assign hi_rank   = total >> 1;
  assign lo_rank   = total[0] ? hi_rank : (hi_rank - CNT_W'(1));
  assign seen_next = seen + count_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      lo_found <= 1'b0;
      hi_found <= 1'b0;
      seen     <= '0;
    end else if (ctrl.clear) begin
      lo_found <= 1'b0;
      hi_found <= 1'b0;
      seen     <= '0;
    end else if (ctrl.step) begin
      seen <= seen_next;
      if (!lo_found && (seen_next > lo_rank)) begin
        lo_found <= 1'b1;
      end
      if (!hi_found && (seen_next > hi_rank)) begin
        hi_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step && !lo_found && (seen_next > lo_rank)) begin
      lo_val <= ctrl.bin;
    end
    if (ctrl.step && !hi_found && (seen_next > hi_rank)) begin
      hi_val <= ctrl.bin;
    end
  end

  assign mid_sum = {1'b0, lo_val} + {1'b0, hi_val};
  assign median  = mid_sum[BIN_W:1];

endmodule

FILE: hdl/pixel_median_engine_core.sv
// Top level of the pixel median engine: histogram cell chain, rank evaluator and control.
//
//   Channel   Dir  Fields (low bit first)                      Handshake
//   s_axis    in   tdata: pixel_value[7:0]; tlast: last_pixel  tvalid/tready
//   m_axis    out  tdata: median_value[7:0]                    tvalid/tready
//
// Pixels are taken one per cycle while collecting; each bumps its bin cell until
// MAX_PIXELS are counted. After the pixel with tlast, the 256 cells shift their
// counts into the evaluator, one bin per cycle, then load the result when the
// output is free. s_axis_tready is low during the scan and until the result is loaded.
// Synchronous reset clears all bin counts, the pixel count and the output valid.
`include "pixel_median_engine_core_macros.svh"

module pixel_median_engine_core
  import pme_pkg::*;
#(
  parameter int MAX_PIXELS = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [PIX_W-1:0] s_axis_tdata,   // [7:0] pixel_value
  input  logic             s_axis_tlast,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [PIX_W-1:0] m_axis_tdata    // [7:0] median_value
);

  localparam int CNT_W = $clog2(MAX_PIXELS + 1);

  pme_state_t       state;
  pme_state_t       state_next;
  logic [CNT_W-1:0] total;
  logic [BIN_W-1:0] scan_idx;
  logic [PIX_W-1:0] median;
  logic             in_accept;
  logic             not_full;
  logic             load_out;
  pme_cell_ctrl_t   cell_ctrl;
  pme_eval_ctrl_t   eval_ctrl;
  logic [CNT_W-1:0] chain [0:NUM_BINS];

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign not_full  = (total != CNT_W'(MAX_PIXELS));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_COLLECT: begin
        if (in_accept && s_axis_tlast) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_idx == BIN_W'(NUM_BINS - 1)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_next = ST_COLLECT;
        end
      end
      default: begin
        state_next = ST_COLLECT;
      end
    endcase
  end

  always_comb begin
    s_axis_tready      = 1'b0;
    load_out           = 1'b0;
    cell_ctrl.count_en = 1'b0;
    cell_ctrl.shift    = 1'b0;
    cell_ctrl.pixel    = s_axis_tdata;
    eval_ctrl.clear    = 1'b0;
    eval_ctrl.step     = 1'b0;
    eval_ctrl.bin      = scan_idx;
    case (state)
      ST_COLLECT: begin
        s_axis_tready      = 1'b1;
        cell_ctrl.count_en = s_axis_tvalid && not_full;
        eval_ctrl.clear    = s_axis_tvalid && s_axis_tlast;
      end
      ST_SCAN: begin
        cell_ctrl.shift = 1'b1;
        eval_ctrl.step  = 1'b1;
      end
      ST_FINISH: begin
        load_out = !m_axis_tvalid || m_axis_tready;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total    <= '0;
      scan_idx <= '0;
    end else begin
      if (load_out) begin
        total <= '0;
      end else if (in_accept && not_full) begin
        total <= total + CNT_W'(1);
      end
      if (state == ST_SCAN) begin
        scan_idx <= scan_idx + BIN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tdata <= median;
    end
  end

  assign chain[NUM_BINS] = '0;

  for (genvar b = 0; b < NUM_BINS; b++) begin : g_cell
    pme_hist_cell #(
      .CNT_W (CNT_W),
      .BIN   (b)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (cell_ctrl),
      .count_in  (chain[b+1]),
      .count_out (chain[b])
    );
  end

  pme_rank_eval #(
    .CNT_W (CNT_W)
  ) u_eval (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (eval_ctrl),
    .total    (total),
    .count_in (chain[0]),
    .median   (median)
  );

  `PME_ASSERT_NEXT(a_last_starts_scan, in_accept && s_axis_tlast, (state == ST_SCAN) && (total != '0))
  `PME_ASSERT_NEXT(a_scan_ends, (state == ST_SCAN) && (scan_idx == BIN_W'(NUM_BINS - 1)), state == ST_FINISH)
  `PME_ASSERT_NEXT(a_load_clears, load_out, m_axis_tvalid && (total == '0) && (chain[0] == '0))
  `PME_ASSERT_SAME(a_total_bound, 1'b1, total <= CNT_W'(MAX_PIXELS))

endmodule
